### src/kpar_pkg.sv
`default_nettype none
package kpar_pkg;

   localparam int unsigned KeyW   = 10;
   localparam int unsigned CountW = 8;
   localparam int unsigned CsrIdxW = 1;

   localparam logic [KeyW-1:0]   KeyMask       = 10'h3ff;
   localparam logic [CountW-1:0] DelayReset    = 8'd60;
   localparam logic [CountW-1:0] PeriodReset   = 8'd30;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_REPEAT_DELAY  = 1'b0,
      CSR_REPEAT_PERIOD = 1'b1
   } kpar_csr_type;

   typedef struct packed {
      logic [KeyW-1:0] held;
      logic [KeyW-1:0] down;
      logic [KeyW-1:0] up;
      logic [KeyW-1:0] repeat_keys;
   } kpar_masks_type;

   typedef struct packed {
      kpar_masks_type    masks;
      logic [CountW-1:0] countdown;
   } kpar_state_type;

   typedef struct packed {
      logic ack_down;
      logic ack_up;
      logic ack_repeat;
   } kpar_ack_type;

endpackage
`default_nettype wire

### src/kpar_scan.sv
`default_nettype none
module kpar_scan (
   input  kpar_pkg::kpar_state_type   state_cur,
   input  logic [kpar_pkg::KeyW-1:0]   raw_keys,
   input  kpar_pkg::kpar_ack_type     ack,
   input  logic [kpar_pkg::CountW-1:0] repeat_delay,
   input  logic [kpar_pkg::CountW-1:0] repeat_period,
   output kpar_pkg::kpar_state_type   state_next
);
   import kpar_pkg::*;

   logic [KeyW-1:0]   prev;
   logic [KeyW-1:0]   now;
   logic [KeyW-1:0]   pressed;
   logic [KeyW-1:0]   released;
   logic [KeyW-1:0]   down;
   logic [KeyW-1:0]   up;
   logic [KeyW-1:0]   rep;
   logic [CountW-1:0] count;
   logic [CountW-1:0] count_dec;

   always_comb begin
      prev     = state_cur.masks.held;
      now      = ~raw_keys & KeyMask;
      pressed  = now & ~prev;
      released = prev & ~now;

      // acknowledge clears first, so this scan's events stay visible
      down = ack.ack_down   ? '0 : state_cur.masks.down;
      up   = ack.ack_up     ? '0 : state_cur.masks.up;
      rep  = ack.ack_repeat ? '0 : state_cur.masks.repeat_keys;

      down = (down | pressed) & ~released;
      rep  = (rep  | pressed) & ~released;
      up   = (up | released) & ~pressed;

      count     = (prev != now) ? repeat_delay : state_cur.countdown;
      count_dec = count - 1'b1;
      if (repeat_delay != '0) begin
         if (count_dec == '0) begin
            count = repeat_period;
            rep   = rep | now;
         end else begin
            count = count_dec;
         end
      end

      state_next.masks.held        = now;
      state_next.masks.down        = down;
      state_next.masks.up          = up;
      state_next.masks.repeat_keys = rep;
      state_next.countdown         = count;
   end

endmodule
`default_nettype wire

### src/keypad_edge_and_auto_repeat_core.sv
`default_nettype none
// Keypad edge detector with auto repeat.
// Input channel (req_*): one word per frame with the active-low keypad pins
// and three acknowledge bits that clear the sticky down, up and repeat masks
// before the scan. Result channel (rsp_*): one word per input word with the
// held, down, up and repeat masks after that scan.
// An accepted word is registered in the result register, or in the skid
// register while a result waits. Throughput is one word per cycle while
// req_stall is low; scan and countdown are one logic pass into state_ff.
// A two-entry output (result register plus one skid register) lets the block
// take a new word while a result waits; req_stall rises only when both are
// full, and stays registered so it never depends on rsp_stall in the same
// cycle. While rsp_stall is high the presented result holds.
// Configuration (csr_*): index 0 is repeat_delay, index 1 repeat_period;
// csr_ready is always high. Write only while the block is idle.
// Reset clears all masks, loads the countdown with 60, delay 60, period 30,
// and empties the output stages.
module keypad_edge_and_auto_repeat_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [kpar_pkg::KeyW-1:0]      req_raw_keys,
   input  logic                           req_ack_down,
   input  logic                           req_ack_up,
   input  logic                           req_ack_repeat,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kpar_pkg::KeyW-1:0]      rsp_held_mask,
   output logic [kpar_pkg::KeyW-1:0]      rsp_down_mask,
   output logic [kpar_pkg::KeyW-1:0]      rsp_up_mask,
   output logic [kpar_pkg::KeyW-1:0]      rsp_repeat_mask,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kpar_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [kpar_pkg::CountW-1:0]    csr_wdata
);
   import kpar_pkg::*;

   logic [CountW-1:0] delay_ff;
   logic [CountW-1:0] period_ff;
   kpar_state_type    state_ff;
   kpar_state_type    state_in;
   kpar_ack_type      ack;
   kpar_masks_type    out_ff;
   kpar_masks_type    skid_ff;
   logic              out_valid_ff;
   logic              skid_valid_ff;
   logic              accept;
   logic              take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;

   assign ack.ack_down   = req_ack_down;
   assign ack.ack_up     = req_ack_up;
   assign ack.ack_repeat = req_ack_repeat;

   kpar_scan u_scan (
      .state_cur     (state_ff),
      .raw_keys      (req_raw_keys),
      .ack           (ack),
      .repeat_delay  (delay_ff),
      .repeat_period (period_ff),
      .state_next    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DelayReset;
         period_ff <= PeriodReset;
      end else if (csr_valid) begin
         unique case (kpar_csr_type'(csr_index))
            CSR_REPEAT_DELAY:  delay_ff  <= csr_wdata;
            CSR_REPEAT_PERIOD: period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.masks     <= '0;
         state_ff.countdown <= DelayReset;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // result register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || take) begin
            out_ff <= state_in.masks;
         end else begin
            skid_ff <= state_in.masks;
         end
      end else if (take && skid_valid_ff) begin
         // advance the waiting word
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_held_mask   = out_ff.held;
   assign rsp_down_mask   = out_ff.down;
   assign rsp_up_mask     = out_ff.up;
   assign rsp_repeat_mask = out_ff.repeat_keys;

endmodule
`default_nettype wire
